FILE: rtl/mmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared types and constants for the set statistics block.
// ----------------------------------------------------------------------------
package mmm_pkg;

   // input width and result field widths
   localparam int IN_BITS     = 16;
   localparam int COUNT_BITS  = 8;
   localparam int MEAN_BITS   = 23;
   localparam int MEDIAN_BITS = 16;
   localparam int MODE_BITS   = 15;

   // one classified request passed from front to back
   typedef struct packed {
      logic        last;   // set ends with this entry
      logic        store;  // entry carries a value to store
      logic [30:0] value;  // saturated value, upper bits zero
   } entry_type;

   // one finished result
   typedef struct packed {
      logic [COUNT_BITS-1:0]  count;
      logic [MEAN_BITS-1:0]   mean_q8;
      logic [MEDIAN_BITS-1:0] median_x2;
      logic [MODE_BITS-1:0]   mode_value;
      logic [COUNT_BITS-1:0]  mode_count;
      logic                   empty_set;
   } result_type;

endpackage

FILE: rtl/mean_median_mode_of_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_median_mode_of_set_unit
// Count, mean, median and mode of a set of non-negative values.
// ----------------------------------------------------------------------------
// Usage: requests carry one signed value each on req_value (req_valid and
// req_ready). Non-negative values join the current set; a negative value
// ends it, as does the value that fills MAX_COUNT entries. Each set gives
// one response on the rsp_ channel (rsp_valid and rsp_ready).
// A front stage classifies requests into a two-entry queue; the back stage
// inserts each value into a sorted register chain, so values load at one
// per cycle while the back is in its load state. At set end the back shifts
// the chain out past its head, one entry a cycle, then a bit-serial divider
// forms the mean. The back takes values again once the response is
// registered. Reset is synchronous and empties the queue and the set. A
// stalled response holds its register; the front keeps accepting until the
// queue fills.
// ----------------------------------------------------------------------------
module mean_median_mode_of_set_unit #(
   parameter int MAX_COUNT  = 128,
   parameter int VALUE_BITS = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mmm_pkg::IN_BITS-1:0]     req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mmm_pkg::COUNT_BITS-1:0]  rsp_count,
   output logic [mmm_pkg::MEAN_BITS-1:0]   rsp_mean_q8,
   output logic [mmm_pkg::MEDIAN_BITS-1:0] rsp_median_x2,
   output logic [mmm_pkg::MODE_BITS-1:0]   rsp_mode_value,
   output logic [mmm_pkg::COUNT_BITS-1:0]  rsp_mode_count,
   output logic                            rsp_empty_set
);
   logic q_valid, q_ready;
   mmm_pkg::entry_type q_entry;
   mmm_pkg::result_type res;

   mmm_front #(.MAX_COUNT(MAX_COUNT), .VALUE_BITS(VALUE_BITS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry));

   mmm_back #(.MAX_COUNT(MAX_COUNT), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_entry(q_entry), .r_valid(rsp_valid), .r_ready(rsp_ready), .r_data(res));

   // unpack the response
   assign rsp_count      = res.count;
   assign rsp_mean_q8    = res.mean_q8;
   assign rsp_median_x2  = res.median_x2;
   assign rsp_mode_value = res.mode_value;
   assign rsp_mode_count = res.mode_count;
   assign rsp_empty_set  = res.empty_set;
endmodule

FILE: rtl/mmm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_front
// Accepts requests, saturates values, marks set ends, feeds a short queue.
// ----------------------------------------------------------------------------
module mmm_front #(
   parameter int MAX_COUNT  = 128,
   parameter int VALUE_BITS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [mmm_pkg::IN_BITS-1:0] req_value,
   output logic                       q_valid,
   input  logic                       q_ready,
   output mmm_pkg::entry_type         q_entry
);
   localparam int CW = $clog2(MAX_COUNT + 1);
   localparam int QD = 2;

   logic [CW-1:0] fill_ff, fill_in;
   mmm_pkg::entry_type q_mem_ff [QD];
   logic q_wp_ff, q_rp_ff;
   logic [1:0] q_n_ff;
   mmm_pkg::entry_type cls;
   logic [30:0] sat;
   logic acc, pop;

   assign req_ready = (q_n_ff != 2'd2);
   assign acc = req_valid && req_ready;
   assign q_valid = (q_n_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_entry = q_mem_ff[q_rp_ff];

   // saturate and classify
   always_comb begin
      sat = 31'(req_value[14:0]);
      if (VALUE_BITS < 15 && req_value[14:0] > 15'((1 << VALUE_BITS) - 1))
         sat = 31'((1 << VALUE_BITS) - 1);
      cls.store = !req_value[15];
      cls.value = sat;
      cls.last  = req_value[15] || (32'(fill_ff) + 32'd1 >= 32'(MAX_COUNT));
      fill_in = fill_ff;
      if (acc) fill_in = cls.last ? '0 : fill_ff + CW'(1);
   end

   // queue and set fill tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         q_wp_ff <= 1'b0;
         q_rp_ff <= 1'b0;
         q_n_ff  <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (acc) q_wp_ff <= ~q_wp_ff;
         if (pop) q_rp_ff <= ~q_rp_ff;
         q_n_ff <= q_n_ff + {1'b0, acc} - {1'b0, pop};
      end
      if (acc) q_mem_ff[q_wp_ff] <= cls;
   end
endmodule

FILE: rtl/mmm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmm_divider #(
   parameter int NB = 40,
   parameter int DB = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NB-1:0] num,
   input  logic [DB-1:0] den,
   output logic          done,
   output logic [NB-1:0] quo
);
   localparam int SB = $clog2(NB + 1);
   logic [NB-1:0] q_ff;
   logic [DB:0]   r_ff;
   logic [SB-1:0] n_ff;
   logic          busy_ff;
   logic [DB:0]   t;

   assign done = busy_ff && (n_ff == '0);
   assign quo  = q_ff;
   assign t = {r_ff[DB-1:0], q_ff[NB-1]};

   // shift and subtract
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         n_ff <= SB'(NB);
         q_ff <= num;
         r_ff <= '0;
      end else if (busy_ff && n_ff != '0) begin
         n_ff <= n_ff - SB'(1);
         if (t >= {1'b0, den}) begin
            r_ff <= t - {1'b0, den};
            q_ff <= {q_ff[NB-2:0], 1'b1};
         end else begin
            r_ff <= t;
            q_ff <= {q_ff[NB-2:0], 1'b0};
         end
      end else begin
         busy_ff <= 1'b0;
      end
   end
endmodule

FILE: rtl/mmm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmm_back
// Sorted insertion into a register chain, running sum, end of set scan.
// ----------------------------------------------------------------------------
module mmm_back #(
   parameter int MAX_COUNT  = 128,
   parameter int VALUE_BITS = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  mmm_pkg::entry_type  q_entry,
   output logic                r_valid,
   input  logic                r_ready,
   output mmm_pkg::result_type r_data
);
   localparam int CW = $clog2(MAX_COUNT + 1);
   localparam int SW = VALUE_BITS + CW;
   localparam int NB = SW + 8;
   localparam logic [2:0] S_LOAD = 3'd0, S_SCAN = 3'd1, S_DIV = 3'd2,
                          S_WAIT = 3'd3, S_OUT = 3'd4;

   logic [2:0] st_ff;
   logic [VALUE_BITS-1:0] chain_ff [MAX_COUNT];
   logic [VALUE_BITS-1:0] lower [MAX_COUNT];
   logic [VALUE_BITS-1:0] upper [MAX_COUNT];
   logic [CW-1:0] n_ff, idx_ff;
   logic [SW-1:0] sum_ff;
   logic [VALUE_BITS-1:0] v, run_v_ff, best_v_ff, cur;
   logic [CW-1:0] run_c_ff, best_c_ff, run_c_in;
   logic [VALUE_BITS+1:0] med_ff;
   logic div_start, div_done;
   logic [NB-1:0] quo;
   mmm_pkg::result_type res_ff;
   logic rv_ff;

   assign v = q_entry.value[VALUE_BITS-1:0];
   assign q_ready = (st_ff == S_LOAD);
   assign r_valid = rv_ff;
   assign r_data = res_ff;
   assign cur = chain_ff[0];
   assign div_start = (st_ff == S_DIV);
   assign run_c_in = (idx_ff != '0 && cur == run_v_ff) ? run_c_ff + CW'(1) : CW'(1);

   mmm_divider #(.NB(NB), .DB(CW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num({sum_ff, 8'd0}), .den(n_ff), .done(div_done), .quo(quo));

   // neighbor taps of every cell; below the head counts as zero
   always_comb begin
      lower[0] = '0;
      for (int i = 1; i < MAX_COUNT; i++) lower[i] = chain_ff[i-1];
      for (int i = 0; i < MAX_COUNT - 1; i++) upper[i] = chain_ff[i+1];
      upper[MAX_COUNT-1] = chain_ff[MAX_COUNT-1];
   end

   // sorted chain: each cell keeps, shifts or takes the new value;
   // during the scan the chain shifts toward its head
   always_ff @(posedge clock) begin
      if (st_ff == S_LOAD && q_valid && q_entry.store) begin
         for (int i = 0; i < MAX_COUNT; i++) begin
            if ((i < 32'(n_ff) && chain_ff[i] > v) || i == 32'(n_ff))
               chain_ff[i] <= (lower[i] <= v) ? v : lower[i];
         end
      end else if (st_ff == S_SCAN) begin
         for (int i = 0; i < MAX_COUNT; i++) chain_ff[i] <= upper[i];
      end
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD;
         n_ff <= '0;
         sum_ff <= '0;
         rv_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (rv_ff && r_ready && st_ff != S_OUT) rv_ff <= 1'b0;
         case (st_ff)
            S_LOAD: begin
               if (q_valid) begin
                  if (q_entry.store) begin
                     n_ff <= n_ff + CW'(1);
                     sum_ff <= sum_ff + SW'(v);
                  end
                  if (q_entry.last) begin
                     idx_ff <= '0;
                     st_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (n_ff == '0) begin
                  st_ff <= S_OUT;
               end else begin
                  run_v_ff <= cur;
                  run_c_ff <= run_c_in;
                  if (idx_ff == '0 || run_c_in > best_c_ff) begin
                     best_c_ff <= run_c_in;
                     best_v_ff <= cur;
                  end
                  if ({1'b0, idx_ff} == ({1'b0, n_ff} >> 1)) begin
                     if (n_ff[0]) med_ff <= {1'b0, cur, 1'b0};
                     else med_ff <= med_ff + (VALUE_BITS+2)'(cur);
                  end else if ({1'b0, idx_ff} + 1'b1 == ({1'b0, n_ff} >> 1)) begin
                     med_ff <= (VALUE_BITS+2)'(cur);
                  end
                  idx_ff <= idx_ff + CW'(1);
                  if (idx_ff + CW'(1) == n_ff) st_ff <= S_DIV;
               end
            end
            S_DIV: st_ff <= S_WAIT;
            S_WAIT: if (div_done) st_ff <= S_OUT;
            S_OUT: begin
               if (!rv_ff || r_ready) begin
                  rv_ff <= 1'b1;
                  if (n_ff == '0) begin
                     res_ff.count <= '0;
                     res_ff.mean_q8 <= '0;
                     res_ff.median_x2 <= '0;
                     res_ff.mode_value <= '0;
                     res_ff.mode_count <= '0;
                     res_ff.empty_set <= 1'b1;
                  end else begin
                     res_ff.count <= 8'(n_ff);
                     res_ff.mean_q8 <= 23'(quo);
                     res_ff.median_x2 <= 16'(med_ff);
                     res_ff.mode_value <= 15'(best_v_ff);
                     res_ff.mode_count <= 8'(best_c_ff);
                     res_ff.empty_set <= 1'b0;
                  end
                  n_ff <= '0;
                  sum_ff <= '0;
                  st_ff <= S_LOAD;
               end
            end
            default: st_ff <= S_LOAD;
         endcase
      end
   end
endmodule

FILE: sim/mean_median_mode_of_set_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_median_mode_of_set_unit_tb
// Self-checking bench for the set statistics block: a directed table of
// request values, then random sets of varied size, checked against a
// behavioral model of count, mean, median and mode under random idling.
// ----------------------------------------------------------------------------
module mean_median_mode_of_set_unit_tb;

   localparam int SET_CAP   = 128;
   localparam int VAL_MAX   = 32767;
   localparam int CYC_LIMIT = 1000000;

   // one row of the directed table; has_exp marks a typed-in result
   typedef struct {
      logic [mmm_pkg::IN_BITS-1:0] value;
      bit                          has_exp;
      mmm_pkg::result_type         exp;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [mmm_pkg::IN_BITS-1:0]     req_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mmm_pkg::COUNT_BITS-1:0]  rsp_count;
   logic [mmm_pkg::MEAN_BITS-1:0]   rsp_mean_q8;
   logic [mmm_pkg::MEDIAN_BITS-1:0] rsp_median_x2;
   logic [mmm_pkg::MODE_BITS-1:0]   rsp_mode_value;
   logic [mmm_pkg::COUNT_BITS-1:0]  rsp_mode_count;
   logic                            rsp_empty_set;

   // stats state of the set being collected
   int unsigned set_vals[$];
   longint unsigned set_sum;
   mmm_pkg::result_type stats_queue[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   stim_row_type dir_rows[$];

   mean_median_mode_of_set_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_count(rsp_count), .rsp_mean_q8(rsp_mean_q8),
      .rsp_median_x2(rsp_median_x2), .rsp_mode_value(rsp_mode_value),
      .rsp_mode_count(rsp_mode_count), .rsp_empty_set(rsp_empty_set)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // statistics of the current set, then clear it
   function automatic mmm_pkg::result_type close_set();
      mmm_pkg::result_type r;
      int unsigned srt[$];
      int n, run_cnt, best_cnt;
      int unsigned run_val, best_val;
      r = '0;
      n = set_vals.size();
      if (n == 0) begin
         r.empty_set = 1'b1;
      end else begin
         srt = set_vals;
         srt.sort();
         r.count = n[mmm_pkg::COUNT_BITS-1:0];
         r.mean_q8 = mmm_pkg::MEAN_BITS'((set_sum * 256) / n);
         if (n % 2 == 0) r.median_x2 = mmm_pkg::MEDIAN_BITS'(srt[n/2-1] + srt[n/2]);
         else r.median_x2 = mmm_pkg::MEDIAN_BITS'(srt[n/2] * 2);
         best_cnt = 0; best_val = srt[0]; run_val = srt[0]; run_cnt = 0;
         foreach (srt[i]) begin
            if (srt[i] == run_val) run_cnt++;
            else begin
               run_val = srt[i];
               run_cnt = 1;
            end
            if (run_cnt > best_cnt) begin
               best_cnt = run_cnt;
               best_val = run_val;
            end
         end
         r.mode_value = mmm_pkg::MODE_BITS'(best_val);
         r.mode_count = mmm_pkg::COUNT_BITS'(best_cnt);
      end
      set_vals.delete();
      set_sum = 0;
      return r;
   endfunction

   // apply one accepted request to the model
   function automatic bit stats_step(logic [mmm_pkg::IN_BITS-1:0] v,
                                     output mmm_pkg::result_type r);
      int unsigned sv;
      if (v[mmm_pkg::IN_BITS-1]) begin
         r = close_set();
         return 1;
      end
      sv = 32'(v);
      if (sv > VAL_MAX) sv = VAL_MAX;
      set_vals.push_back(sv);
      set_sum += sv;
      if (set_vals.size() >= SET_CAP) begin
         r = close_set();
         return 1;
      end
      r = '0;
      return 0;
   endfunction

   // send one request and record its expected result
   task automatic send_value(logic [mmm_pkg::IN_BITS-1:0] v, bit has_exp,
                             mmm_pkg::result_type exp);
      mmm_pkg::result_type r;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (stats_step(v, r)) begin
         if (has_exp && r != exp) begin
            $error("directed row value %0d: typed result %p, model %p", v, exp, r);
            fail_count++;
         end
         stats_queue.push_back(r);
      end
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // random request value: small, anywhere in range, or near the largest value
   function automatic logic [mmm_pkg::IN_BITS-1:0] rand_value(int kind);
      case (kind)
         0: return mmm_pkg::IN_BITS'($urandom_range(7));
         1: return mmm_pkg::IN_BITS'($urandom_range(VAL_MAX));
         default: return mmm_pkg::IN_BITS'($urandom_range(VAL_MAX - 7, VAL_MAX));
      endcase
   endfunction

   task automatic send_set(int len, int kind);
      for (int i = 0; i < len; i++) send_value(rand_value(kind), 0, '0);
      if (len < SET_CAP)
         send_value(mmm_pkg::IN_BITS'($urandom_range(16'hFFFF, 16'h8000)), 0, '0);
   endtask

   // response side: random stall, check against oldest expectation
   always @(posedge clock) begin
      mmm_pkg::result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (stats_queue.size() == 0) begin
               $error("response with none expected");
               fail_count++;
            end else begin
               e = stats_queue.pop_front();
               if (rsp_count !== e.count) begin
                  $error("count exp %0d got %0d", e.count, rsp_count); fail_count++;
               end
               if (rsp_mean_q8 !== e.mean_q8) begin
                  $error("mean_q8 exp %0d got %0d", e.mean_q8, rsp_mean_q8); fail_count++;
               end
               if (rsp_median_x2 !== e.median_x2) begin
                  $error("median_x2 exp %0d got %0d", e.median_x2, rsp_median_x2);
                  fail_count++;
               end
               if (rsp_mode_value !== e.mode_value) begin
                  $error("mode_value exp %0d got %0d", e.mode_value, rsp_mode_value);
                  fail_count++;
               end
               if (rsp_mode_count !== e.mode_count) begin
                  $error("mode_count exp %0d got %0d", e.mode_count, rsp_mode_count);
                  fail_count++;
               end
               if (rsp_empty_set !== e.empty_set) begin
                  $error("empty_set exp %0d got %0d", e.empty_set, rsp_empty_set);
                  fail_count++;
               end
            end
         end
         rsp_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYC_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic mmm_pkg::result_type mk_res(int c, int m, int md, int mv, int mc,
                                                  bit e);
      mmm_pkg::result_type r;
      r.count = mmm_pkg::COUNT_BITS'(c);
      r.mean_q8 = mmm_pkg::MEAN_BITS'(m);
      r.median_x2 = mmm_pkg::MEDIAN_BITS'(md);
      r.mode_value = mmm_pkg::MODE_BITS'(mv);
      r.mode_count = mmm_pkg::COUNT_BITS'(mc);
      r.empty_set = e;
      return r;
   endfunction

   function automatic void add_row(logic [mmm_pkg::IN_BITS-1:0] v, bit h,
                                   mmm_pkg::result_type e);
      stim_row_type row;
      row.value = v; row.has_exp = h; row.exp = e;
      dir_rows.push_back(row);
   endfunction

   initial begin
      int ph, len, kind;
      set_sum = 0;
      // directed table: empty set, extremes, ties, even and odd medians
      add_row(16'h8000, 1, mk_res(0, 0, 0, 0, 0, 1));            // empty set
      add_row(16'hFFFF, 1, mk_res(0, 0, 0, 0, 0, 1));            // empty again
      add_row(16'd32767, 0, '0);
      add_row(16'hFFFF, 1, mk_res(1, 32767 * 256, 65534, 32767, 1, 0));
      add_row(16'd0, 0, '0);
      add_row(16'h8000, 1, mk_res(1, 0, 0, 0, 1, 0));
      add_row(16'd5, 0, '0);
      add_row(16'd3, 0, '0);
      add_row(16'd5, 0, '0);
      add_row(16'd3, 0, '0);                                     // tie: smaller
      add_row(16'hC000, 0, '0);
      add_row(16'd1, 0, '0);
      add_row(16'd2, 0, '0);
      add_row(16'h8001, 1, mk_res(2, 384, 3, 1, 1, 0));
      add_row(16'd32767, 0, '0);
      add_row(16'd0, 0, '0);
      add_row(16'd32767, 0, '0);
      add_row(16'h7FFE, 0, '0);
      add_row(16'hAAAA, 0, '0);
      add_row(16'd21845, 0, '0);
      add_row(16'h8000, 0, '0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_value(dir_rows[i].value, dir_rows[i].has_exp, dir_rows[i].exp);
      // full store of the largest value, no terminator needed
      for (int i = 0; i < SET_CAP; i++) send_value(16'd32767, 0, '0);
      // pause until all expected responses arrive
      drop_valid();
      while (stats_queue.size() != 0) @(posedge clock);
      // random phases with different idling
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 12 : 0;
         recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 12 : 0;
         for (int s = 0; s < 20; s++) begin
            kind = $urandom_range(2);
            len = ($urandom_range(19) == 0) ? SET_CAP : $urandom_range(12);
            send_set(len, kind);
         end
      end
      drop_valid();
      while (stats_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: mean_median_mode_of_set_unit.f
rtl/mmm_pkg.sv
rtl/mmm_front.sv
rtl/mmm_divider.sv
rtl/mmm_back.sv
rtl/mean_median_mode_of_set_unit.sv
sim/mean_median_mode_of_set_unit_tb.sv
